// ===== design/glh_pkg.sv =====
// Shared constants, field types and inter-module structs of the gray-level histogram.
// Depends on nothing; every other file imports it.
package glh_pkg;

  localparam int NUM_BINS   = 256;
  localparam int COUNT_BITS = 16;
  localparam int BIN_W      = $clog2(NUM_BINS);

  localparam int OP_W      = 2;
  localparam int VAL_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int CEIL_W    = 8;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Quotient bits resolved by the divider; the ceiling never exceeds them.
  localparam int HQ_W   = CEIL_W;
  localparam int STEP_W = $clog2(HQ_W + 1);
  localparam int PROD_W = GAIN_W + COUNT_BITS;
  localparam int SH_W   = COUNT_BITS + HQ_W;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_ADD   = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam cfg_idx_t CFG_GAIN = 1'd0;
  localparam cfg_idx_t CFG_CEIL = 1'd1;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd1024;
  localparam logic [CEIL_W-1:0] CEIL_RST = 8'd93;

  // Read request leaving the read-modify-write stage.
  typedef struct packed {
    logic                  vld;
    logic [COUNT_BITS-1:0] count;
    logic [COUNT_BITS-1:0] total;
  } glh_rd_t;

  // Finished read result.
  typedef struct packed {
    logic [CEIL_W-1:0] height;
    logic [OUT_W-1:0]  count;
    logic [OUT_W-1:0]  seen;
  } glh_res_t;

endpackage

// ===== design/glh_in_if.sv =====
// Input channel of the histogram: valid/ready handshake plus the item fields.
// Depends on glh_pkg.
interface glh_in_if;
  import glh_pkg::*;

  logic             valid;
  logic             ready;
  op_t              op;
  logic [VAL_W-1:0] sample_value;
  logic [VAL_W-1:0] bin_index;

  modport source (output valid, output op, output sample_value, output bin_index,
                  input ready);
  modport sink   (input valid, input op, input sample_value, input bin_index,
                  output ready);
endinterface

// ===== design/glh_out_if.sv =====
// Result channel of the histogram: valid/ready handshake plus the result fields.
// Depends on glh_pkg.
interface glh_out_if;
  import glh_pkg::*;

  logic              valid;
  logic              ready;
  logic [CEIL_W-1:0] bin_height;
  logic [OUT_W-1:0]  bin_count;
  logic [OUT_W-1:0]  samples_seen;

  modport source (output valid, output bin_height, output bin_count, output samples_seen,
                  input ready);
  modport sink   (input valid, input bin_height, input bin_count, input samples_seen,
                  output ready);
endinterface

// ===== design/gray_level_histogram_normalizer.sv =====
// Top level of the gray-level histogram with normalized bin heights.
// Depends on glh_pkg, glh_in_if, glh_out_if, glh_bin_store and glh_height_div.
//
//   Channel   Direction  Handshake             Carries
//   in_ch     input      valid/ready           op, sample_value, bin_index
//   out_ch    output     valid/ready           bin_height, bin_count, samples_seen
//   cfg_*     input      cfg_we, no wait       height_gain (index 0), height_ceiling (1)
//
// Add and clear items are taken one per cycle through the read-modify-write stage while
// no read holds in_ch.ready low; a write or clear made at the edge where the next item
// reads the memory is forwarded to it. A read item holds in_ch.ready low in the memory
// stage, the HQ_W + 1 divider steps and the handover to the output register; an empty
// histogram skips the divider steps, an overflow stops after the first. A waiting result
// stalls nothing until a second read has finished in the divider and waits behind it.
// Synchronous reset clears the bin valid bits at once, so no clearing pass is needed.
module gray_level_histogram_normalizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  glh_pkg::cfg_idx_t             cfg_idx,
  input  logic [glh_pkg::CFG_DAT_W-1:0] cfg_wdata,
  glh_in_if.sink                        in_ch,
  glh_out_if.source                     out_ch
);
  import glh_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [CEIL_W-1:0] ceil_r;

  logic              in_acc;
  glh_rd_t           rd;
  glh_res_t          res;
  logic              div_idle;
  logic              div_done;
  logic              res_take;

  logic              out_vld_r;
  glh_res_t          out_res_r;

  // Configuration registers; writes must only come while the block is idle (unenforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      ceil_r <= CEIL_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_GAIN) begin
        gain_r <= cfg_wdata[GAIN_W-1:0];
      end else if (cfg_idx == CFG_CEIL) begin
        ceil_r <= cfg_wdata[CEIL_W-1:0];
      end
    end
  end

  // A read in the memory stage or in the divider blocks new items, because the
  // divider takes exactly one request at a time.
  assign in_ch.ready = !rd.vld && div_idle;
  assign in_acc      = in_ch.valid && in_ch.ready;

  glh_bin_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .op           (in_ch.op),
    .sample_value (in_ch.sample_value),
    .bin_index    (in_ch.bin_index),
    .rd           (rd)
  );

  glh_height_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .gain    (gain_r),
    .ceiling (ceil_r),
    .rd      (rd),
    .take    (res_take),
    .idle    (div_idle),
    .done    (div_done),
    .res     (res)
  );

  // Output register: the finished result moves here when it is empty or being drained.
  assign res_take = div_done && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.bin_height   = out_res_r.height;
  assign out_ch.bin_count    = out_res_r.count;
  assign out_ch.samples_seen = out_res_r.seen;

  a_no_accept_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd.vld |-> !in_acc)
    else $error("item accepted while a read occupied the memory stage");

  a_height_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.height <= ceil_r))
    else $error("reported height exceeds the ceiling");

endmodule

// ===== design/glh_bin_store.sv =====
// Bin counter memory with its read-modify-write stage, valid bits and sample total.
// Depends on glh_pkg.
module glh_bin_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  glh_pkg::op_t              op,
  input  logic [glh_pkg::VAL_W-1:0] sample_value,
  input  logic [glh_pkg::VAL_W-1:0] bin_index,
  output glh_pkg::glh_rd_t          rd
);
  import glh_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   valid_r;

  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;

  logic                  s1_vld_r;
  op_t                   s1_op_r;
  logic [BIN_W-1:0]      s1_addr_r;
  logic                  s1_inr_r;

  logic                  fw_wr_r;
  logic                  fw_clr_r;
  logic [BIN_W-1:0]      fw_addr_r;
  logic [COUNT_BITS-1:0] fw_data_r;

  logic [COUNT_BITS-1:0] total_r;
  logic [COUNT_BITS-1:0] total_nxt;

  logic [BIN_W-1:0]      rd_addr;
  logic                  rd_inr;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cur_inc;
  logic                  do_wr;
  logic                  do_clr;

  always_comb begin
    if (op == OP_ADD) begin
      rd_addr = BIN_W'(sample_value);
      rd_inr  = (32'(sample_value) < NUM_BINS);
    end else begin
      rd_addr = BIN_W'(bin_index);
      rd_inr  = (32'(bin_index) < NUM_BINS);
    end
  end

  // The entry read at acceptance misses a write or clear made at that same edge.
  always_comb begin
    if (fw_clr_r) begin
      cur = '0;
    end else if (fw_wr_r && (fw_addr_r == s1_addr_r)) begin
      cur = fw_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
    cur_inc = (cur == CNT_MAX) ? cur : cur + 1'b1;
  end

  assign do_wr  = s1_vld_r && (s1_op_r == OP_ADD) && s1_inr_r;
  assign do_clr = s1_vld_r && (s1_op_r == OP_CLEAR);

  always_comb begin
    total_nxt = total_r;
    if (do_clr) begin
      total_nxt = '0;
    end else if (do_wr && (total_r != CNT_MAX)) begin
      total_nxt = total_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      bin_mem[s1_addr_r] <= cur_inc;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= bin_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      s1_vld_r <= 1'b0;
      fw_wr_r  <= 1'b0;
      fw_clr_r <= 1'b0;
      total_r  <= '0;
    end else begin
      if (do_clr) begin
        valid_r <= '0;
      end else if (do_wr) begin
        valid_r[s1_addr_r] <= 1'b1;
      end
      s1_vld_r <= acc;
      fw_wr_r  <= do_wr;
      fw_clr_r <= do_clr;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r  <= valid_r[rd_addr];
    s1_op_r   <= op;
    s1_addr_r <= rd_addr;
    s1_inr_r  <= rd_inr;
    fw_addr_r <= s1_addr_r;
    fw_data_r <= cur_inc;
  end

  always_comb begin
    rd.vld   = s1_vld_r && (s1_op_r == OP_READ);
    rd.count = s1_inr_r ? cur : '0;
    rd.total = total_r;
  end

  a_clr_total: assert property (@(posedge clk) disable iff (!rst_n)
    do_clr |=> (total_r == '0))
    else $error("sample total not zero after a clear");

  a_add_total: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && (total_r != CNT_MAX)) |=> (total_r == $past(total_r) + 1'b1))
    else $error("sample total did not advance on an add");

endmodule

// ===== design/glh_height_div.sv =====
// Height unit: gain times count, then a restoring divide by the total, clamped to the ceiling.
// Depends on glh_pkg.
module glh_height_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [glh_pkg::GAIN_W-1:0] gain,
  input  logic [glh_pkg::CEIL_W-1:0] ceiling,
  input  glh_pkg::glh_rd_t           rd,
  input  logic                       take,
  output logic                       idle,
  output logic                       done,
  output glh_pkg::glh_res_t          res
);
  import glh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } div_state_t;

  div_state_t            state_r;
  logic [PROD_W-1:0]     rem_r;
  logic [SH_W-1:0]       sh_r;
  logic [STEP_W-1:0]     step_r;
  logic [HQ_W-1:0]       q_r;
  logic                  ovf_r;
  logic                  zero_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] total_r;

  logic                  ge;
  logic                  first;

  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(w);
  endfunction

  assign ge    = (rem_r >= PROD_W'(sh_r));
  assign first = (step_r == STEP_W'(HQ_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (rd.vld) begin
            state_r <= (rd.total == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if ((ge && first) || (step_r == '0)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && rd.vld) begin
      rem_r   <= PROD_W'(gain) * PROD_W'(rd.count);
      sh_r    <= {rd.total, {HQ_W{1'b0}}};
      step_r  <= STEP_W'(HQ_W);
      q_r     <= '0;
      ovf_r   <= 1'b0;
      zero_r  <= (rd.total == '0);
      count_r <= rd.count;
      total_r <= rd.total;
    end else if (state_r == S_RUN) begin
      if (ge && first) begin
        ovf_r <= 1'b1;
      end else begin
        if (ge) begin
          rem_r <= rem_r - PROD_W'(sh_r);
        end
        q_r    <= {q_r[HQ_W-2:0], ge};
        sh_r   <= sh_r >> 1;
        step_r <= step_r - 1'b1;
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      res.height = '0;
    end else if (ovf_r || (q_r > ceiling)) begin
      res.height = ceiling;
    end else begin
      res.height = q_r;
    end
    res.count = sat_out(count_r);
    res.seen  = sat_out(total_r);
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd.vld |-> (state_r == S_IDLE))
    else $error("read request arrived while the divider was busy");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (step_r <= STEP_W'(HQ_W)))
    else $error("divider step counter out of range");

endmodule

// ===== tb/sv/gray_level_histogram_normalizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the gray-level histogram with normalized bin heights.
// It sends add, read and clear items, predicts each read result from a shadow histogram,
// and compares the results field by field. Depends on glh_pkg, glh_in_if, glh_out_if and
// gray_level_histogram_normalizer.
module gray_level_histogram_normalizer_tb;
  import glh_pkg::*;

  // The block ignores op 3. The package names no constant for it, so it is named here.
  localparam op_t OP_UNUSED = 2'd3;

  // Slack after the last expected result. It covers any item still in flight.
  localparam int SETTLE_CYCLES = HQ_W + 8;

  typedef logic [COUNT_BITS-1:0] count_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_t             cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  glh_in_if  in_bus ();
  glh_out_if out_bus ();

  gray_level_histogram_normalizer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  // Shadow copy of the histogram, the sample total and the two registers. Reads push the
  // result they should produce onto readouts_due, which the checker drains in order.
  count_t            shadow_bins [NUM_BINS];
  count_t            shadow_total;
  logic [GAIN_W-1:0] shadow_gain;
  logic [CEIL_W-1:0] shadow_ceiling;
  glh_res_t          readouts_due [$];
  glh_res_t          readout_head;

  int unsigned mismatch_count = 0;

  // Random idling. The sender leaves gaps before items. The receiver drops ready in random
  // bursts. Both are switched off for the last part of the run.
  bit          idle_on    = 1'b1;
  bit          stall_on   = 1'b1;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  // This is the guard against a hung handshake. A correct run takes well under a tenth of it.
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void wipe_shadow();
    foreach (shadow_bins[b]) shadow_bins[b] = '0;
    shadow_total = '0;
  endfunction

  // Apply one accepted item to the shadow histogram. For a read, queue the expected result.
  // The height is floor(gain * count / total), clamped to the ceiling. It is zero while
  // the histogram is empty, so there is never a division by zero.
  function automatic void histogram_apply(op_t op, logic [VAL_W-1:0] sv,
                                          logic [VAL_W-1:0] bi);
    glh_res_t          readout;
    longint unsigned   quotient;
    count_t            count;
    case (op)
      OP_ADD: begin
        // The bin and the total saturate independently of each other.
        if (shadow_bins[sv] != '1) shadow_bins[sv] = shadow_bins[sv] + 1'b1;
        if (shadow_total != '1) shadow_total = shadow_total + 1'b1;
      end
      OP_READ: begin
        count = shadow_bins[bi];
        if (shadow_total == '0) begin
          quotient = 0;
        end else begin
          quotient = (longint'(shadow_gain) * longint'(count)) / longint'(shadow_total);
        end
        if (quotient > longint'(shadow_ceiling)) quotient = longint'(shadow_ceiling);
        readout.height = quotient[CEIL_W-1:0];
        readout.count  = OUT_W'(count);
        readout.seen   = OUT_W'(shadow_total);
        readouts_due.push_back(readout);
      end
      OP_CLEAR: begin
        wipe_shadow();
      end
      default: begin
        // Op 3 changes nothing and produces no result.
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Result checker. Outputs are sampled at the rising edge, where the handshake completes.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (readouts_due.size() == 0) begin
        flag_mismatch("unrequested result, bin_count", 0, out_bus.bin_count);
      end else begin
        readout_head = readouts_due.pop_front();
        if (out_bus.bin_height !== readout_head.height)
          flag_mismatch("bin_height", readout_head.height, out_bus.bin_height);
        if (out_bus.bin_count !== readout_head.count)
          flag_mismatch("bin_count", readout_head.count, out_bus.bin_count);
        if (out_bus.samples_seen !== readout_head.seen)
          flag_mismatch("samples_seen", readout_head.seen, out_bus.samples_seen);
      end
    end
  end

  // Result-side backpressure. The value is chosen at the falling edge and holds through
  // the next rising edge.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Send one item. The task is entered at a falling edge and returns at the falling edge
  // after acceptance. Valid is left high, so the next item can follow back to back.
  // Anything that pauses the sender lowers valid itself.
  task automatic push_item(input op_t op, input logic [VAL_W-1:0] sv,
                           input logic [VAL_W-1:0] bi);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.op           <= op;
    in_bus.sample_value <= sv;
    in_bus.bin_index    <= bi;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    histogram_apply(op, sv, bi);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected result, then let any add or clear in flight
  // finish. Registers are written only after this.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (readouts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write both registers on consecutive edges. The ceiling write carries random upper data
  // bits, which the 8-bit register must drop.
  task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [CEIL_W-1:0] ceil);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GAIN;
    cfg_wdata <= CFG_DAT_W'(gain);
    @(posedge clk);
    shadow_gain = gain;
    @(negedge clk);
    cfg_idx   <= CFG_CEIL;
    cfg_wdata <= {8'($urandom), ceil};
    @(posedge clk);
    shadow_ceiling = ceil;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset values of the registers, the empty histogram, the extreme gray levels, op 3 and
  // clear, with no register written yet.
  task automatic test_empty_and_reset_values();
    push_item(OP_READ, 8'd0, 8'd0);
    push_item(OP_READ, 8'hA5, 8'd255);
    push_item(OP_UNUSED, 8'd255, 8'd255);
    push_item(OP_ADD, 8'd0, 8'd255);
    push_item(OP_ADD, 8'd255, 8'd0);
    push_item(OP_ADD, 8'd255, 8'h5A);
    push_item(OP_ADD, 8'd128, 8'd1);
    push_item(OP_READ, 8'd3, 8'd255);
    push_item(OP_READ, 8'd255, 8'd0);
    push_item(OP_READ, 8'd0, 8'd128);
    push_item(OP_READ, 8'd0, 8'd17);
    push_item(OP_UNUSED, 8'd0, 8'd0);
    push_item(OP_READ, 8'd0, 8'd0);
    push_item(OP_CLEAR, 8'd255, 8'd255);
    push_item(OP_READ, 8'd0, 8'd255);
    push_item(OP_ADD, 8'd77, 8'd0);
    push_item(OP_READ, 8'd0, 8'd77);
    settle();
  endtask

  // Zero gain, the largest gain, unit gain, and a zero and a full ceiling.
  task automatic test_register_extremes();
    set_config(16'd0, 8'd255);
    push_item(OP_ADD, 8'd5, 8'd0);
    push_item(OP_ADD, 8'd5, 8'd0);
    push_item(OP_ADD, 8'd6, 8'd0);
    push_item(OP_READ, 8'd0, 8'd5);
    push_item(OP_READ, 8'd0, 8'd6);
    settle();
    set_config(16'd65535, 8'd255);
    push_item(OP_READ, 8'd0, 8'd5);
    push_item(OP_READ, 8'd0, 8'd6);
    settle();
    set_config(16'd1, 8'd255);
    push_item(OP_READ, 8'd0, 8'd5);
    push_item(OP_CLEAR, 8'd0, 8'd0);
    push_item(OP_ADD, 8'd9, 8'd0);
    push_item(OP_READ, 8'd0, 8'd9);
    settle();
    set_config(16'd65535, 8'd0);
    push_item(OP_READ, 8'd0, 8'd9);
    settle();
  endtask

  // One bin takes nearly every sample while another gets only a few. The largest gain
  // pushes the quotient of the big bin past any ceiling; a smaller gain still clamps the big
  // bin to it but leaves the small bin well under it.
  task automatic test_dominant_bin();
    set_config(16'd65535, 8'd255);
    push_item(OP_CLEAR, 8'd0, 8'd0);
    repeat (3) push_item(OP_ADD, 8'd3, 8'($urandom));
    repeat (40) push_item(OP_ADD, 8'd200, 8'($urandom));
    push_item(OP_READ, 8'($urandom), 8'd200);
    push_item(OP_READ, 8'($urandom), 8'd3);
    settle();
    set_config(16'd300, 8'd255);
    push_item(OP_READ, 8'($urandom), 8'd200);
    push_item(OP_READ, 8'($urandom), 8'd3);
    push_item(OP_ADD, 8'd3, 8'($urandom));
    push_item(OP_READ, 8'($urandom), 8'd3);
    push_item(OP_CLEAR, 8'd0, 8'd0);
    push_item(OP_READ, 8'($urandom), 8'd200);
    settle();
  endtask

  // Random traffic in several register settings. Adds dominate, as they do at pixel rate.
  // Most samples and reads fall in a narrow window of bins, so the counts grow large
  // enough for the heights to spread between zero and the ceiling. The last phase runs
  // with no idling on either side.
  task automatic test_random_traffic();
    logic [GAIN_W-1:0] gain;
    logic [CEIL_W-1:0] ceil;
    logic [VAL_W-1:0]  hot_base;
    logic [VAL_W-1:0]  sv;
    logic [VAL_W-1:0]  bi;
    op_t               op;
    int unsigned       roll;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin gain = GAIN_RST;  ceil = CEIL_RST; end
        1: begin gain = 16'd1;     ceil = 8'd255;   end
        2: begin gain = 16'd65535; ceil = 8'd0;     end
        3: begin gain = 16'd0;     ceil = 8'd200;   end
        4: begin gain = 16'($urandom_range(1, 4095)); ceil = 8'($urandom); end
        default: begin gain = 16'($urandom_range(64, 2048)); ceil = 8'd255; end
      endcase
      if (phase == 5) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      set_config(gain, ceil);
      hot_base = VAL_W'($urandom_range(0, 252));
      for (int n = 0; n < 285; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 74)      op = OP_ADD;
        else if (roll < 94) op = OP_READ;
        else if (roll < 97) op = OP_CLEAR;
        else                op = OP_UNUSED;
        sv = ($urandom_range(0, 9) < 7) ? hot_base + VAL_W'($urandom_range(0, 3))
                                        : VAL_W'($urandom);
        bi = ($urandom_range(0, 9) < 6) ? hot_base + VAL_W'($urandom_range(0, 3))
                                        : VAL_W'($urandom);
        push_item(op, sv, bi);
      end
      // The sender waits here until every expected result has come back.
      settle();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_GAIN;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.op           = OP_ADD;
    in_bus.sample_value = '0;
    in_bus.bin_index    = '0;
    out_bus.ready       = 1'b0;
    shadow_gain         = GAIN_RST;
    shadow_ceiling      = CEIL_RST;
    wipe_shadow();

    // Synchronous reset is held low from time zero and released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_reset_values();
    test_register_extremes();
    test_dominant_bin();
    test_random_traffic();

    // Every phase ends in settle(), so all expected results are already in. Any left over
    // here after one more settling pause is a missing result.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (readouts_due.size() != 0) begin
      $display("%0d expected results never arrived", readouts_due.size());
      mismatch_count += readouts_due.size();
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
